>>> sv/agap_pkg.sv
// Package for the affine-gap edit operation counter.
// Holds sizes, word and memory entry types, state codes and the saturating add.
// No dependencies.
`timescale 1ns / 1ps

package agap_pkg;

   localparam int MAX_LEN    = 256;
   localparam int COST_WIDTH = 20;
   localparam int CNT_W      = 10;
   localparam int CP_W       = 21;
   localparam int STR_AW     = $clog2(MAX_LEN);
   localparam int LEN_W      = $clog2(MAX_LEN + 1);
   localparam int ROW_DEPTH  = MAX_LEN + 1;
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 32;

   typedef logic [COST_WIDTH-1:0] cost_type;

   typedef struct packed {
      logic [CNT_W-1:0] match_k;
      logic [CNT_W-1:0] mismatch_k;
      logic [CNT_W-1:0] trans_k;
      logic [CNT_W-1:0] open_k;
      logic [CNT_W-1:0] ext_k;
   } counts_type;

   typedef struct packed {
      cost_type   cost;
      counts_type counts;
   } row_entry_type;

   typedef struct packed {
      logic            non_character;
      logic [CP_W-1:0] code_point;
   } char_type;

   typedef struct packed {
      logic            op;
      logic [CP_W-1:0] code_point;
      logic            non_character;
      logic            empty_req;
      logic            last;
   } req_word_type;

   typedef struct packed {
      logic [8:0] match_count;
      logic [8:0] mismatch_count;
      logic [8:0] transposition_count;
      logic [9:0] gap_open_count;
      logic [9:0] gap_extension_count;
      logic       too_long;
   } rsp_word_type;

   typedef enum logic [2:0] {
      REG_GAP_OPEN   = 3'd0,
      REG_GAP_EXTEND = 3'd1,
      REG_MATCH      = 3'd2,
      REG_MISMATCH   = 3'd3,
      REG_TRANSPOSE  = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      ALN_OPEN,
      ALN_EXTEND,
      ALN_MATCH,
      ALN_MISMATCH,
      ALN_TRANS
   } aln_op_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_START,
      ST_EQ_RD,
      ST_EQ_CMP,
      ST_INIT_Z,
      ST_INIT_T,
      ST_INIT_W,
      ST_ROW_RD,
      ST_ROW_RD2,
      ST_ROW_WR,
      ST_ROW_E,
      ST_CELL_RD,
      ST_CELL_RD2,
      ST_CELL_C1,
      ST_CELL_C2,
      ST_CELL_C3,
      ST_CELL_WR,
      ST_CELL_CPY,
      ST_ROW_END,
      ST_FIN_RD,
      ST_FIN_CAP,
      ST_OUT
   } state_type;

   function automatic cost_type sat_add(input cost_type a, input logic [7:0] b);
      logic [COST_WIDTH:0] s;
      s = {1'b0, a} + {{(COST_WIDTH-7){1'b0}}, b};
      return s[COST_WIDTH] ? '1 : s[COST_WIDTH-1:0];
   endfunction

endpackage

>>> sv/affine_gap_edit_op_counter.sv
// Top level of the affine-gap edit operation counter: string load, Gotoh row sweep, result.
// Depends on agap_pkg and agap_ram (two string memories, two row memories).
//
//   channel   direction  handshake                       payload
//   req       in         req_valid / req_ready           req_word (one character)
//   rsp       out        rsp_valid / rsp_ready           rsp_word (operation counts)
//   csr       in/out     psel penable pwrite, pready=1   paddr, pwdata, prdata
//
// Load: one character per cycle. The closing character starts the alignment; equal
// length strings are first compared position by position, then row zero is filled,
// each row is swept cell by cell (a transposition also writes the next cell), then the
// result is read: each cell cost is set by one read-modify-write of the row memories.
// req_ready is low from the closing character until the result enters the output register.
// Reset is synchronous; no memory clearing is needed.
`timescale 1ns / 1ps

module affine_gap_edit_op_counter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  agap_pkg::req_word_type        req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output agap_pkg::rsp_word_type        rsp_word,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [agap_pkg::CSR_AW-1:0]   paddr,
   input  logic [agap_pkg::CSR_DW-1:0]   pwdata,
   output logic [agap_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);

   import agap_pkg::*;

   // control
   state_type        state_ff, state_in;
   logic [LEN_W-1:0] len0_ff, len0_in, len1_ff, len1_in;
   logic             done0_ff, done0_in, done1_ff, done1_in;
   logic             over0_ff, over0_in, over1_ff, over1_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       go_ff, go_in, ge_ff, ge_in, mc_ff, mc_in, xc_ff, xc_in, tc_ff, tc_in;

   // datapath
   rsp_word_type     rsp_word_ff, rsp_word_in;
   logic             swap_ff, swap_in;
   logic [LEN_W-1:0] m_ff, m_in, n_ff, n_in, j_ff, j_in, i_ff, i_in;
   cost_type         t_ff, t_in, e_ff, e_in, c_ff, c_in, s_ff, s_in;
   cost_type         bcost_ff, bcost_in, dcost_ff, dcost_in;
   cost_type         co_ff, co_in, bo_ff, bo_in, dnew_ff, dnew_in, sw_ff, sw_in;
   cost_type         mn_ff, mn_in, min_cost_ff, min_cost_in;
   logic [CNT_W-1:0] base_ext_ff, base_ext_in;
   counts_type       pc_ff, pc_in, prr_ff, prr_in, bcnt_ff, bcnt_in, dcnt_ff, dcnt_in;
   counts_type       cur_ff, cur_in, res_cnt_ff, res_cnt_in;
   char_type         c1_ff, c1_in, c2_ff, c2_in, c2n_ff, c2n_in;
   logic [7:0]       w_ff, w_in;
   logic             tr_ff, tr_in, both_ff, both_in, mlike_ff, mlike_in;
   logic             ins_open_ff, ins_open_in, del_open_ff, del_open_in;
   logic             have_min_ff, have_min_in, row_trans_ff, row_trans_in;
   logic             res_over_ff, res_over_in;
   aln_op_type       op_ff, op_in;

   // memory ports
   logic              s0_we, s1_we;
   logic [STR_AW-1:0] s0_waddr, s1_waddr, s0_raddr, s1_raddr, col_addr, row_addr;
   char_type          s_wdata, s0_rdata, s1_rdata, u1_data, u2_data;
   logic              best_we, del_we;
   logic [LEN_W-1:0]  best_waddr, del_waddr, best_raddr;
   row_entry_type     best_wdata, del_wdata, best_rdata, del_rdata;

   // shared combinational terms
   logic             acc, sel, cur_done, load_hits, finish_load;
   logic             done0_nx, done1_nx, csr_wr;
   logic [LEN_W-1:0] cur_len, j_p1, j_p2, j_m1, i_next;
   logic [2:0]       csr_idx;
   counts_type       base_cnt, base_inc, de_w, ds_w, cur_w, zero_cnt;
   logic             neq_c1, both_c1, tr_c1;
   logic             from_e_c3, from_diag_c3;
   cost_type         t_ge, t_go;

   assign acc       = req_valid & req_ready;
   assign sel       = req_word.op;
   assign cur_done  = sel ? done1_ff : done0_ff;
   assign cur_len   = sel ? len1_ff : len0_ff;
   assign load_hits = acc & ~cur_done;
   assign done0_nx  = done0_ff | (load_hits & ~sel & (req_word.empty_req | req_word.last));
   assign done1_nx  = done1_ff | (load_hits & sel & (req_word.empty_req | req_word.last));
   assign finish_load = load_hits & done0_nx & done1_nx;

   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_idx = paddr[CSR_AW-1:2];
   assign pready  = 1'b1;

   assign j_p1   = j_ff + LEN_W'(1);
   assign j_p2   = j_ff + LEN_W'(2);
   assign j_m1   = j_ff - LEN_W'(1);
   assign i_next = i_ff + (row_trans_ff ? LEN_W'(2) : LEN_W'(1));

   assign t_ge = sat_add(t_ff, ge_ff);
   assign t_go = sat_add(t_ff, go_ff);

   assign zero_cnt = '0;
   assign base_cnt = '{match_k: '0, mismatch_k: '0, trans_k: '0,
                       open_k: CNT_W'(1), ext_k: base_ext_ff};
   assign base_inc = '{match_k: '0, mismatch_k: '0, trans_k: '0,
                       open_k: CNT_W'(1), ext_k: base_ext_ff + CNT_W'(1)};

   assign u1_data  = swap_ff ? s1_rdata : s0_rdata;
   assign u2_data  = swap_ff ? s0_rdata : s1_rdata;
   assign s0_raddr = swap_ff ? row_addr : col_addr;
   assign s1_raddr = swap_ff ? col_addr : row_addr;

   // substitution weight and transposition test
   assign neq_c1  = c1_ff.code_point != c2_ff.code_point;
   assign both_c1 = c1_ff.non_character & c2_ff.non_character;
   assign tr_c1   = neq_c1 && (j_ff < m_ff) && !both_c1
                    && (c2_ff.code_point == u1_data.code_point)
                    && (i_ff < n_ff) && (c1_ff.code_point == c2n_ff.code_point);

   // pick the cheapest source of the cell
   assign from_e_c3    = e_ff < dnew_ff;
   assign from_diag_c3 = from_e_c3 ? (sw_ff < e_ff) : (sw_ff < dnew_ff);

   always_comb begin
      de_w = del_open_ff ? bcnt_ff : dcnt_ff;
      ds_w = de_w;
      if (del_open_ff) begin
         ds_w.open_k = de_w.open_k + CNT_W'(1);
      end
      ds_w.ext_k = de_w.ext_k + CNT_W'(1);
   end

   always_comb begin
      cur_w = cur_ff;
      case (op_ff)
         ALN_MATCH: begin
            if (!both_ff) cur_w.match_k = cur_ff.match_k + CNT_W'(1);
         end
         ALN_MISMATCH: cur_w.mismatch_k = cur_ff.mismatch_k + CNT_W'(1);
         ALN_EXTEND:   cur_w.ext_k = cur_ff.ext_k + CNT_W'(1);
         ALN_OPEN: begin
            cur_w.open_k = cur_ff.open_k + CNT_W'(1);
            cur_w.ext_k  = cur_ff.ext_k + CNT_W'(1);
         end
         ALN_TRANS:    cur_w.trans_k = cur_ff.trans_k + CNT_W'(1);
         default:      cur_w = cur_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (finish_load) state_in = ST_START;
         end
         ST_START: begin
            if (over0_ff || over1_ff) state_in = ST_OUT;
            else if (len0_ff == len1_ff) state_in = (len0_ff == '0) ? ST_OUT : ST_EQ_RD;
            else state_in = ST_INIT_Z;
         end
         ST_EQ_RD: state_in = ST_EQ_CMP;
         ST_EQ_CMP: begin
            if (u1_data.code_point != u2_data.code_point) state_in = ST_INIT_Z;
            else if (j_p1 == m_ff) state_in = ST_OUT;
            else state_in = ST_EQ_RD;
         end
         ST_INIT_Z: state_in = ST_INIT_T;
         ST_INIT_T: state_in = ST_INIT_W;
         ST_INIT_W: begin
            if (j_ff == m_ff) state_in = (n_ff == '0) ? ST_FIN_RD : ST_ROW_RD;
            else state_in = ST_INIT_T;
         end
         ST_ROW_RD:   state_in = ST_ROW_RD2;
         ST_ROW_RD2:  state_in = ST_ROW_WR;
         ST_ROW_WR:   state_in = ST_ROW_E;
         ST_ROW_E:    state_in = ST_CELL_RD;
         ST_CELL_RD:  state_in = ST_CELL_RD2;
         ST_CELL_RD2: state_in = ST_CELL_C1;
         ST_CELL_C1:  state_in = ST_CELL_C2;
         ST_CELL_C2:  state_in = ST_CELL_C3;
         ST_CELL_C3:  state_in = ST_CELL_WR;
         ST_CELL_WR: begin
            if (op_ff == ALN_TRANS) state_in = ST_CELL_CPY;
            else if (j_p1 > m_ff) state_in = ST_ROW_END;
            else state_in = ST_CELL_RD;
         end
         ST_CELL_CPY: state_in = (j_p2 > m_ff) ? ST_ROW_END : ST_CELL_RD;
         ST_ROW_END:  state_in = (i_next > n_ff) ? ST_FIN_RD : ST_ROW_RD;
         ST_FIN_RD:   state_in = ST_FIN_CAP;
         ST_FIN_CAP:  state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // memory controls and handshake outputs
   always_comb begin
      req_ready  = (state_ff == ST_LOAD);
      s_wdata    = '{non_character: req_word.non_character, code_point: req_word.code_point};
      s0_we      = (state_ff == ST_LOAD) && load_hits && !req_word.empty_req && !sel
                   && (len0_ff < LEN_W'(MAX_LEN));
      s1_we      = (state_ff == ST_LOAD) && load_hits && !req_word.empty_req && sel
                   && (len1_ff < LEN_W'(MAX_LEN));
      s0_waddr   = len0_ff[STR_AW-1:0];
      s1_waddr   = len1_ff[STR_AW-1:0];
      col_addr   = j_ff[STR_AW-1:0];
      row_addr   = j_ff[STR_AW-1:0];
      best_raddr = j_ff;
      best_we    = 1'b0;
      best_waddr = j_ff;
      best_wdata = '{cost: mn_ff, counts: cur_w};
      del_we     = 1'b0;
      del_waddr  = j_ff;
      del_wdata  = '{cost: dnew_ff, counts: ds_w};
      case (state_ff)
         ST_INIT_Z: begin
            best_we    = 1'b1;
            best_waddr = '0;
            best_wdata = '{cost: '0, counts: zero_cnt};
         end
         ST_INIT_W: begin
            best_we    = 1'b1;
            best_wdata = '{cost: t_ff, counts: base_cnt};
            del_we     = 1'b1;
            del_wdata  = '{cost: t_go, counts: base_cnt};
         end
         ST_ROW_RD: begin
            best_raddr = '0;
            row_addr   = j_m1[STR_AW-1:0];
            row_addr   = LEN_W'(i_ff - LEN_W'(1)) >= LEN_W'(0) ?
                         STR_AW'(i_ff - LEN_W'(1)) : '0;
         end
         ST_ROW_RD2: row_addr = i_ff[STR_AW-1:0];
         ST_ROW_WR: begin
            best_we    = 1'b1;
            best_waddr = '0;
            best_wdata = '{cost: t_ge, counts: base_inc};
         end
         ST_CELL_RD: col_addr = j_m1[STR_AW-1:0];
         ST_CELL_WR: begin
            best_we = 1'b1;
            del_we  = 1'b1;
         end
         ST_CELL_CPY: begin
            best_we    = 1'b1;
            best_waddr = j_p1;
            best_wdata = '{cost: c_ff, counts: pc_ff};
         end
         ST_FIN_RD: best_raddr = m_ff;
         default: best_we = 1'b0;
      endcase
   end

   // register next values
   always_comb begin
      len0_in = len0_ff;   len1_in = len1_ff;
      done0_in = done0_ff; done1_in = done1_ff;
      over0_in = over0_ff; over1_in = over1_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      go_in = go_ff; ge_in = ge_ff; mc_in = mc_ff; xc_in = xc_ff; tc_in = tc_ff;
      rsp_word_in = rsp_word_ff;
      swap_in = swap_ff; m_in = m_ff; n_in = n_ff; j_in = j_ff; i_in = i_ff;
      t_in = t_ff; e_in = e_ff; c_in = c_ff; s_in = s_ff;
      bcost_in = bcost_ff; dcost_in = dcost_ff;
      co_in = co_ff; bo_in = bo_ff; dnew_in = dnew_ff; sw_in = sw_ff;
      mn_in = mn_ff; min_cost_in = min_cost_ff; base_ext_in = base_ext_ff;
      pc_in = pc_ff; prr_in = prr_ff; bcnt_in = bcnt_ff; dcnt_in = dcnt_ff;
      cur_in = cur_ff; res_cnt_in = res_cnt_ff;
      c1_in = c1_ff; c2_in = c2_ff; c2n_in = c2n_ff;
      w_in = w_ff; tr_in = tr_ff; both_in = both_ff; mlike_in = mlike_ff;
      ins_open_in = ins_open_ff; del_open_in = del_open_ff;
      have_min_in = have_min_ff; row_trans_in = row_trans_ff;
      res_over_in = res_over_ff; op_in = op_ff;

      if (csr_wr) begin
         case (csr_idx)
            REG_GAP_OPEN:   go_in = pwdata[7:0];
            REG_GAP_EXTEND: ge_in = pwdata[7:0];
            REG_MATCH:      mc_in = pwdata[7:0];
            REG_MISMATCH:   xc_in = pwdata[7:0];
            REG_TRANSPOSE:  tc_in = pwdata[7:0];
            default:        go_in = go_ff;
         endcase
      end

      case (state_ff)
         ST_LOAD: begin
            if (load_hits) begin
               if (req_word.empty_req) begin
                  if (sel) begin
                     len1_in = '0; over1_in = 1'b0;
                  end else begin
                     len0_in = '0; over0_in = 1'b0;
                  end
               end else if (cur_len < LEN_W'(MAX_LEN)) begin
                  if (sel) len1_in = len1_ff + LEN_W'(1);
                  else len0_in = len0_ff + LEN_W'(1);
               end else begin
                  if (sel) over1_in = 1'b1;
                  else over0_in = 1'b1;
               end
               done0_in = done0_nx;
               done1_in = done1_nx;
            end
         end
         ST_START: begin
            swap_in     = len0_ff < len1_ff;
            m_in        = (len0_ff < len1_ff) ? len1_ff : len0_ff;
            n_in        = (len0_ff < len1_ff) ? len0_ff : len1_ff;
            j_in        = '0;
            res_over_in = over0_ff | over1_ff;
            res_cnt_in  = zero_cnt;
         end
         ST_EQ_CMP: begin
            j_in = j_p1;
            if (u1_data.code_point == u2_data.code_point && j_p1 == m_ff) begin
               res_cnt_in.match_k = CNT_W'(n_ff);
            end
         end
         ST_INIT_Z: begin
            t_in        = {{(COST_WIDTH-8){1'b0}}, go_ff};
            base_ext_in = '0;
            j_in        = LEN_W'(1);
         end
         ST_INIT_T: begin
            t_in        = t_ge;
            base_ext_in = base_ext_ff + CNT_W'(1);
         end
         ST_INIT_W: begin
            j_in = j_p1;
            if (j_ff == m_ff) begin
               t_in        = {{(COST_WIDTH-8){1'b0}}, go_ff};
               base_ext_in = '0;
               i_in        = LEN_W'(1);
            end
         end
         ST_ROW_RD2: begin
            s_in   = best_rdata.cost;
            prr_in = best_rdata.counts;
            c2_in  = u2_data;
         end
         ST_ROW_WR: begin
            c2n_in      = u2_data;
            t_in        = t_ge;
            base_ext_in = base_ext_ff + CNT_W'(1);
            c_in        = t_ge;
            pc_in       = base_inc;
         end
         ST_ROW_E: begin
            e_in         = t_go;
            have_min_in  = 1'b0;
            row_trans_in = 1'b0;
            j_in         = LEN_W'(1);
         end
         ST_CELL_RD2: begin
            bcost_in = best_rdata.cost;
            bcnt_in  = best_rdata.counts;
            dcost_in = del_rdata.cost;
            dcnt_in  = del_rdata.counts;
            c1_in    = u1_data;
         end
         ST_CELL_C1: begin
            co_in    = sat_add(c_ff, go_ff);
            bo_in    = sat_add(bcost_ff, go_ff);
            tr_in    = tr_c1;
            both_in  = both_c1;
            mlike_in = !neq_c1 || both_c1;
            w_in     = tr_c1 ? tc_ff : ((neq_c1 && !both_c1) ? xc_ff : mc_ff);
         end
         ST_CELL_C2: begin
            ins_open_in = co_ff < e_ff;
            e_in        = sat_add((co_ff < e_ff) ? co_ff : e_ff, ge_ff);
            del_open_in = bo_ff < dcost_ff;
            dnew_in     = sat_add((bo_ff < dcost_ff) ? bo_ff : dcost_ff, ge_ff);
            sw_in       = sat_add(s_ff, w_ff);
         end
         ST_CELL_C3: begin
            if (from_diag_c3) begin
               mn_in  = sw_ff;
               cur_in = prr_ff;
               if (tr_ff) op_in = ALN_TRANS;
               else if (mlike_ff) op_in = ALN_MATCH;
               else op_in = ALN_MISMATCH;
            end else if (from_e_c3) begin
               mn_in  = e_ff;
               cur_in = pc_ff;
               op_in  = ins_open_ff ? ALN_OPEN : ALN_EXTEND;
            end else begin
               mn_in  = dnew_ff;
               cur_in = de_w;
               op_in  = ALN_OPEN;
            end
         end
         ST_CELL_WR: begin
            if (!have_min_ff || mn_ff < min_cost_ff) begin
               have_min_in  = 1'b1;
               row_trans_in = (op_ff == ALN_TRANS);
               min_cost_in  = mn_ff;
            end
            c_in   = mn_ff;
            s_in   = bcost_ff;
            pc_in  = cur_w;
            prr_in = bcnt_ff;
            if (op_ff != ALN_TRANS) j_in = j_p1;
         end
         ST_CELL_CPY: j_in = j_p2;
         ST_ROW_END:  i_in = i_next;
         ST_FIN_CAP:  res_cnt_in = best_rdata.counts;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in.match_count = res_cnt_ff.match_k[CNT_W-1] ?
                                         9'h1FF : res_cnt_ff.match_k[8:0];
               rsp_word_in.mismatch_count = res_cnt_ff.mismatch_k[CNT_W-1] ?
                                            9'h1FF : res_cnt_ff.mismatch_k[8:0];
               rsp_word_in.transposition_count = res_cnt_ff.trans_k[CNT_W-1] ?
                                                 9'h1FF : res_cnt_ff.trans_k[8:0];
               rsp_word_in.gap_open_count      = res_cnt_ff.open_k;
               rsp_word_in.gap_extension_count = res_cnt_ff.ext_k;
               rsp_word_in.too_long            = res_over_ff;
               len0_in  = '0;   len1_in  = '0;
               done0_in = 1'b0; done1_in = 1'b0;
               over0_in = 1'b0; over1_in = 1'b0;
            end
         end
         default: j_in = j_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         len0_ff      <= '0;
         len1_ff      <= '0;
         done0_ff     <= 1'b0;
         done1_ff     <= 1'b0;
         over0_ff     <= 1'b0;
         over1_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         go_ff        <= 8'd3;
         ge_ff        <= 8'd2;
         mc_ff        <= 8'd0;
         xc_ff        <= 8'd6;
         tc_ff        <= 8'd4;
      end else begin
         state_ff     <= state_in;
         len0_ff      <= len0_in;
         len1_ff      <= len1_in;
         done0_ff     <= done0_in;
         done1_ff     <= done1_in;
         over0_ff     <= over0_in;
         over1_ff     <= over1_in;
         rsp_valid_ff <= rsp_valid_in;
         go_ff        <= go_in;
         ge_ff        <= ge_in;
         mc_ff        <= mc_in;
         xc_ff        <= xc_in;
         tc_ff        <= tc_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff  <= rsp_word_in;
      swap_ff      <= swap_in;
      m_ff         <= m_in;
      n_ff         <= n_in;
      j_ff         <= j_in;
      i_ff         <= i_in;
      t_ff         <= t_in;
      e_ff         <= e_in;
      c_ff         <= c_in;
      s_ff         <= s_in;
      bcost_ff     <= bcost_in;
      dcost_ff     <= dcost_in;
      co_ff        <= co_in;
      bo_ff        <= bo_in;
      dnew_ff      <= dnew_in;
      sw_ff        <= sw_in;
      mn_ff        <= mn_in;
      min_cost_ff  <= min_cost_in;
      base_ext_ff  <= base_ext_in;
      pc_ff        <= pc_in;
      prr_ff       <= prr_in;
      bcnt_ff      <= bcnt_in;
      dcnt_ff      <= dcnt_in;
      cur_ff       <= cur_in;
      res_cnt_ff   <= res_cnt_in;
      c1_ff        <= c1_in;
      c2_ff        <= c2_in;
      c2n_ff       <= c2n_in;
      w_ff         <= w_in;
      tr_ff        <= tr_in;
      both_ff      <= both_in;
      mlike_ff     <= mlike_in;
      ins_open_ff  <= ins_open_in;
      del_open_ff  <= del_open_in;
      have_min_ff  <= have_min_in;
      row_trans_ff <= row_trans_in;
      res_over_ff  <= res_over_in;
      op_ff        <= op_in;
   end

   always_comb begin
      case (csr_idx)
         REG_GAP_OPEN:   prdata = {{(CSR_DW-8){1'b0}}, go_ff};
         REG_GAP_EXTEND: prdata = {{(CSR_DW-8){1'b0}}, ge_ff};
         REG_MATCH:      prdata = {{(CSR_DW-8){1'b0}}, mc_ff};
         REG_MISMATCH:   prdata = {{(CSR_DW-8){1'b0}}, xc_ff};
         REG_TRANSPOSE:  prdata = {{(CSR_DW-8){1'b0}}, tc_ff};
         default:        prdata = '0;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   agap_ram #(.WIDTH($bits(char_type)), .DEPTH(MAX_LEN)) u_first_str (
      .clock   (clock),
      .wr_en   (s0_we),
      .wr_addr (s0_waddr),
      .wr_data (s_wdata),
      .rd_addr (s0_raddr),
      .rd_data (s0_rdata)
   );

   agap_ram #(.WIDTH($bits(char_type)), .DEPTH(MAX_LEN)) u_second_str (
      .clock   (clock),
      .wr_en   (s1_we),
      .wr_addr (s1_waddr),
      .wr_data (s_wdata),
      .rd_addr (s1_raddr),
      .rd_data (s1_rdata)
   );

   agap_ram #(.WIDTH($bits(row_entry_type)), .DEPTH(ROW_DEPTH)) u_best_row (
      .clock   (clock),
      .wr_en   (best_we),
      .wr_addr (best_waddr),
      .wr_data (best_wdata),
      .rd_addr (best_raddr),
      .rd_data (best_rdata)
   );

   agap_ram #(.WIDTH($bits(row_entry_type)), .DEPTH(ROW_DEPTH)) u_del_row (
      .clock   (clock),
      .wr_en   (del_we),
      .wr_addr (del_waddr),
      .wr_data (del_wdata),
      .rd_addr (best_raddr),
      .rd_data (del_rdata)
   );

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output state");

   a_long_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.too_long) |->
      (rsp_word.match_count == '0 && rsp_word.mismatch_count == '0 &&
       rsp_word.transposition_count == '0 && rsp_word.gap_open_count == '0 &&
       rsp_word.gap_extension_count == '0))
      else $error("overlong strings gave nonzero counts");

   a_cell_col: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CELL_WR) |-> (j_ff <= m_ff && j_ff != '0))
      else $error("cell column out of range");

   a_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD && state_ff != ST_START) |-> (m_ff >= n_ff))
      else $error("column string shorter than row string");

endmodule

>>> sv/agap_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module agap_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
